### design/mae_pkg.sv
// ----------------------------------------------------------------------------
// mae_pkg: shared types and constants for the motion activity LED envelope
// Holds the configuration record, register indexes, reset values and the
// fixed limits of the brightness and period envelopes.
// ----------------------------------------------------------------------------
package mae_pkg;

  // Field widths.
  localparam int AccelW   = 8;
  localparam int DevW     = 16;
  localparam int BrightW  = 18;
  localparam int StepW    = 18;
  localparam int FloorW   = 8;
  localparam int PeriodW  = 10;
  localparam int CeilW    = 8;
  localparam int ScaleSh  = 10;   // brightness is kept scaled by 1024

  // Configuration port sizes.
  localparam int AddrW    = 5;
  localparam int DataW    = 32;

  // Envelope limits.
  localparam logic [BrightW-1:0] BrtTopScaled = BrightW'(255 * 1024);
  localparam logic [PeriodW-1:0] PeriodTop    = PeriodW'(900);

  // Register reset values.
  localparam logic [DevW-1:0]    RstSteadyLevel    = DevW'(1020);
  localparam logic [DevW-1:0]    RstBrightThresh   = DevW'(126);
  localparam logic [DevW-1:0]    RstSpeedThresh    = DevW'(360);
  localparam logic [StepW-1:0]   RstBrightRise     = StepW'(10008);
  localparam logic [StepW-1:0]   RstBrightFall     = StepW'(207);
  localparam logic [FloorW-1:0]  RstBrightFloor    = FloorW'(22);
  localparam logic [PeriodW-1:0] RstPeriodFloor    = PeriodW'(207);
  localparam logic [PeriodW-1:0] RstPeriodRise     = PeriodW'(2);

  // Register indexes, one per 32-bit word of the configuration space.
  typedef enum logic [2:0] {
    REG_STEADY_LEVEL     = 3'd0,
    REG_BRIGHT_THRESHOLD = 3'd1,
    REG_SPEED_THRESHOLD  = 3'd2,
    REG_BRIGHT_RISE_STEP = 3'd3,
    REG_BRIGHT_FALL_STEP = 3'd4,
    REG_BRIGHT_FLOOR     = 3'd5,
    REG_PERIOD_FLOOR     = 3'd6,
    REG_PERIOD_RISE_STEP = 3'd7
  } reg_idx_t;

  // Configuration record handed from the register file to the datapath.
  typedef struct packed {
    logic [DevW-1:0]    steady_level;
    logic [DevW-1:0]    bright_threshold;
    logic [DevW-1:0]    speed_threshold;
    logic [StepW-1:0]   bright_rise_step;
    logic [StepW-1:0]   bright_fall_step;
    logic [FloorW-1:0]  bright_floor;
    logic [PeriodW-1:0] period_floor;
    logic [PeriodW-1:0] period_rise_step;
  } cfg_t;

endpackage

### design/mae_cfg.sv
// ----------------------------------------------------------------------------
// mae_cfg: configuration register file
// APB-style slave with eight word-aligned registers; writes complete in the
// access phase and reads return the current register value.
// ----------------------------------------------------------------------------
module mae_cfg import mae_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);

  // Register writes; each register keeps only its own width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steady_level     <= RstSteadyLevel;
      cfg.bright_threshold <= RstBrightThresh;
      cfg.speed_threshold  <= RstSpeedThresh;
      cfg.bright_rise_step <= RstBrightRise;
      cfg.bright_fall_step <= RstBrightFall;
      cfg.bright_floor     <= RstBrightFloor;
      cfg.period_floor     <= RstPeriodFloor;
      cfg.period_rise_step <= RstPeriodRise;
    end else if (wr_en) begin
      case (idx)
        REG_STEADY_LEVEL:     cfg.steady_level     <= pwdata[DevW-1:0];
        REG_BRIGHT_THRESHOLD: cfg.bright_threshold <= pwdata[DevW-1:0];
        REG_SPEED_THRESHOLD:  cfg.speed_threshold  <= pwdata[DevW-1:0];
        REG_BRIGHT_RISE_STEP: cfg.bright_rise_step <= pwdata[StepW-1:0];
        REG_BRIGHT_FALL_STEP: cfg.bright_fall_step <= pwdata[StepW-1:0];
        REG_BRIGHT_FLOOR:     cfg.bright_floor     <= pwdata[FloorW-1:0];
        REG_PERIOD_FLOOR:     cfg.period_floor     <= pwdata[PeriodW-1:0];
        REG_PERIOD_RISE_STEP: cfg.period_rise_step <= pwdata[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer, zero-extended to the bus width.
  always_comb begin
    case (idx)
      REG_STEADY_LEVEL:     prdata = DataW'(cfg.steady_level);
      REG_BRIGHT_THRESHOLD: prdata = DataW'(cfg.bright_threshold);
      REG_SPEED_THRESHOLD:  prdata = DataW'(cfg.speed_threshold);
      REG_BRIGHT_RISE_STEP: prdata = DataW'(cfg.bright_rise_step);
      REG_BRIGHT_FALL_STEP: prdata = DataW'(cfg.bright_fall_step);
      REG_BRIGHT_FLOOR:     prdata = DataW'(cfg.bright_floor);
      REG_PERIOD_FLOOR:     prdata = DataW'(cfg.period_floor);
      REG_PERIOD_RISE_STEP: prdata = DataW'(cfg.period_rise_step);
      default:              prdata = '0;
    endcase
  end

endmodule

### design/mae_dev.sv
// ----------------------------------------------------------------------------
// mae_dev: motion deviation
// Squares and sums the three acceleration axes and returns the absolute
// difference from the steady level.
// ----------------------------------------------------------------------------
module mae_dev import mae_pkg::*; (
  input  logic signed [AccelW-1:0] accel_x,
  input  logic signed [AccelW-1:0] accel_y,
  input  logic signed [AccelW-1:0] accel_z,
  input  logic        [DevW-1:0]   steady_level,
  output logic        [DevW-1:0]   deviation
);

  logic signed [2*AccelW-1:0] sq_x, sq_y, sq_z;
  logic        [DevW-1:0]     mag;

  // Each square is at most 16384, so the sum of three fits in 16 bits.
  assign sq_x = (2*AccelW)'(accel_x) * (2*AccelW)'(accel_x);
  assign sq_y = (2*AccelW)'(accel_y) * (2*AccelW)'(accel_y);
  assign sq_z = (2*AccelW)'(accel_z) * (2*AccelW)'(accel_z);
  assign mag  = DevW'(sq_x) + DevW'(sq_y) + DevW'(sq_z);

  // Absolute difference from the resting magnitude.
  assign deviation = (mag > steady_level) ? (mag - steady_level)
                                          : (steady_level - mag);

endmodule

### design/mae_env.sv
// ----------------------------------------------------------------------------
// mae_env: brightness and period envelopes
// Holds the scaled brightness ceiling and the maximum period, and computes
// their saturating updates from the deviation of the current word.
// ----------------------------------------------------------------------------
module mae_env import mae_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               update,
  input  logic [DevW-1:0]    deviation,
  input  cfg_t               cfg,
  output logic [BrightW-1:0] bright_next,
  output logic [PeriodW-1:0] period_next
);

  logic [BrightW-1:0] bright;
  logic [PeriodW-1:0] period;

  logic [BrightW:0]   bright_sum;
  logic [BrightW-1:0] bright_lo;
  logic [BrightW:0]   bright_lo_step;
  logic [PeriodW:0]   period_sum;

  assign bright_sum     = {1'b0, bright} + {1'b0, cfg.bright_rise_step};
  assign bright_lo      = {cfg.bright_floor, {ScaleSh{1'b0}}};
  assign bright_lo_step = {1'b0, bright_lo} + {1'b0, cfg.bright_fall_step};
  assign period_sum     = {1'b0, period} + {1'b0, cfg.period_rise_step};

  // Brightness ceiling: rise on activity up to the top, else fall to the floor.
  always_comb begin
    if (deviation > cfg.bright_threshold) begin
      if (bright_sum < {1'b0, BrtTopScaled}) begin
        bright_next = bright_sum[BrightW-1:0];
      end else begin
        bright_next = BrtTopScaled;
      end
    end else if ({1'b0, bright} > bright_lo_step) begin
      bright_next = bright - cfg.bright_fall_step;
    end else begin
      bright_next = bright_lo;
    end
  end

  // Maximum period: drop to the floor on strong motion, else climb to the top.
  always_comb begin
    if (deviation > cfg.speed_threshold) begin
      period_next = cfg.period_floor;
    end else if (period_sum < {1'b0, PeriodTop}) begin
      period_next = period_sum[PeriodW-1:0];
    end else begin
      period_next = PeriodTop;
    end
  end

  // Envelope state advances once per word leaving the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      bright <= BrtTopScaled;
      period <= PeriodTop;
    end else if (update) begin
      bright <= bright_next;
      period <= period_next;
    end
  end

endmodule

### design/motion_activity_led_envelope.sv
// Stages: an accepted sample is captured in the input register, and its
// result word is then captured in the result register.
// Throughput: one sample per cycle; the input stage takes a new word whenever
// it is empty or the result register is empty or is being taken in the same cycle.
// Reset (synchronous, active high) empties both stages, loads the register
// reset values and sets the ceiling to 255*1024 and the period to 900.
// ----------------------------------------------------------------------------
// motion_activity_led_envelope: accelerometer-driven LED envelope
// Input register, single-pass deviation and envelope update, result register.
// ----------------------------------------------------------------------------
module motion_activity_led_envelope import mae_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // Sample stream.
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [23:0]      s_axis_tdata,   // accel_x[7:0], accel_y[15:8], accel_z[23:16]
  // Result stream.
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // brightness_ceiling[7:0], max_period[17:8],
                                           // deviation[33:18], zero[39:34]
  // Configuration port.
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;

  logic                     in_valid;
  logic signed [AccelW-1:0] in_x, in_y, in_z;
  logic                     advance;
  logic                     update;

  logic [DevW-1:0]    deviation;
  logic [BrightW-1:0] bright_next;
  logic [PeriodW-1:0] period_next;

  logic [CeilW-1:0]   out_ceiling;
  logic [PeriodW-1:0] out_period;
  logic [DevW-1:0]    out_deviation;

  mae_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the result register frees up when empty or being taken.
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign update        = in_valid && advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_x <= s_axis_tdata[7:0];
      in_y <= s_axis_tdata[15:8];
      in_z <= s_axis_tdata[23:16];
    end
  end

  mae_dev u_dev (
    .accel_x      (in_x),
    .accel_y      (in_y),
    .accel_z      (in_z),
    .steady_level (cfg.steady_level),
    .deviation    (deviation)
  );

  mae_env u_env (
    .clk         (clk),
    .rst         (rst),
    .update      (update),
    .deviation   (deviation),
    .cfg         (cfg),
    .bright_next (bright_next),
    .period_next (period_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      out_ceiling   <= bright_next[BrightW-1:ScaleSh];
      out_period    <= period_next;
      out_deviation <= deviation;
    end
  end

  assign m_axis_tdata = {6'd0, out_deviation, out_period, out_ceiling};

  // Both stages are empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !in_valid && !m_axis_tvalid)
    else $error("pipeline not empty after reset");

  // Input stalls only when both stages are full and the output is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a full pipeline");

  // A word leaving the input stage shows up as a result on the next cycle.
  a_move_out: assert property (@(posedge clk) disable iff (rst)
    update |=> m_axis_tvalid)
    else $error("word lost between input and result registers");

  // The brightness ceiling never passes its top.
  a_bright_top: assert property (@(posedge clk) disable iff (rst)
    update |-> bright_next <= BrtTopScaled)
    else $error("brightness ceiling above top");

endmodule
